/* src/sul_pkg.sv */
// ----------------------------------------------------------------------------
// sul_pkg
// Shared types, codes and sizes for the sorted unique list block.
// ----------------------------------------------------------------------------
`default_nettype none

package sul_pkg;

  // Default number of entries
  localparam int DEPTH_DEF = 16;

  // Payload widths
  localparam int VALUE_W  = 32;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // Register map (byte addresses)
  localparam logic [1:0] ADDR_DESCENDING = 2'd0;

  // Item kinds (any other code dumps)
  localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEL = 2'd1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DUMP     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd6;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_DUMP_RD,
    S_DUMP_OUT
  } seq_state_t;

  // Compare unit verdict
  typedef struct packed {
    logic ahead;    // stored entry orders strictly ahead of the search value
    logic equal;    // stored entry equals the search value
  } cmp_res_t;

endpackage

`default_nettype wire

/* src/sul_mem.sv */
// ----------------------------------------------------------------------------
// sul_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sul_mem #(
  parameter int DEPTH = sul_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [sul_pkg::VALUE_W-1:0] wdata,
  input  wire logic                        re,
  input  wire logic [AW-1:0]               raddr,
  output logic      [sul_pkg::VALUE_W-1:0] rdata
);

  logic [sul_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [sul_pkg::VALUE_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* src/sul_cmp.sv */
// ----------------------------------------------------------------------------
// sul_cmp
// Shared compare unit: ordering test and equality of one stored entry
// against the search value, under the ascending/descending setting.
// ----------------------------------------------------------------------------
`default_nettype none

module sul_cmp (
  input  wire logic                        descending,
  input  wire logic [sul_pkg::VALUE_W-1:0] entry,
  input  wire logic [sul_pkg::VALUE_W-1:0] value,
  output sul_pkg::cmp_res_t                res
);

  logic lt_ev;   // entry < value, signed
  logic lt_ve;   // value < entry, signed

  assign lt_ev = $signed(entry) < $signed(value);
  assign lt_ve = $signed(value) < $signed(entry);

  always_comb begin
    res.ahead = descending ? lt_ve : lt_ev;
    res.equal = (entry == value);
  end

endmodule

`default_nettype wire

/* src/sul_seq.sv */
// ----------------------------------------------------------------------------
// sul_seq
// Sequencer: scans the store through the compare unit, shifts entries one
// at a time (a read state, then a write state) for insert and delete, walks
// the store for a dump, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sul_seq #(
  parameter int DEPTH = sul_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input item
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [sul_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [sul_pkg::VALUE_W-1:0]   in_value,
  // result item
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [sul_pkg::STATUS_W-1:0]  out_status,
  output logic      [sul_pkg::VALUE_W-1:0]   out_entry,
  output logic      [sul_pkg::COUNT_W-1:0]   out_count,
  output logic                               out_last,
  // store
  output logic                               mem_we,
  output logic      [AW-1:0]                 mem_waddr,
  output logic      [sul_pkg::VALUE_W-1:0]   mem_wdata,
  output logic                               mem_re,
  output logic      [AW-1:0]                 mem_raddr,
  input  wire logic [sul_pkg::VALUE_W-1:0]   mem_rdata,
  // compare unit
  output logic      [sul_pkg::VALUE_W-1:0]   cmp_value,
  input  wire sul_pkg::cmp_res_t             cmp_res
);

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  sul_pkg::seq_state_t             state_r, state_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [CW-1:0]                   idx_r, idx_nxt;
  logic [CW-1:0]                   pos_r, pos_nxt;
  logic                            found_r, found_nxt;
  logic [sul_pkg::KIND_W-1:0]      kind_r, kind_nxt;
  logic [sul_pkg::VALUE_W-1:0]     val_r, val_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [sul_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [sul_pkg::VALUE_W-1:0]     out_entry_r, out_entry_nxt;
  logic [sul_pkg::COUNT_W-1:0]     out_count_r, out_count_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            out_free;
  logic [CW:0]                     idx_inc;
  logic [CW-1:0]                   idx_dec;
  logic                            idx_at_tail;

  // Entry count as carried in a result: low five bits
  function automatic logic [sul_pkg::COUNT_W-1:0] cnt_field(input logic [CW-1:0] c);
    logic [CW+sul_pkg::COUNT_W-1:0] t;
    t = {{sul_pkg::COUNT_W{1'b0}}, c};
    return t[sul_pkg::COUNT_W-1:0];
  endfunction

  assign out_free    = !out_valid_r || out_ready;
  assign idx_inc     = {1'b0, idx_r} + {{CW{1'b0}}, 1'b1};
  assign idx_dec     = idx_r - {{(CW-1){1'b0}}, 1'b1};
  assign idx_at_tail = (idx_inc == {1'b0, count_r});

  assign in_ready   = (state_r == sul_pkg::S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_entry  = out_entry_r;
  assign out_count  = out_count_r;
  assign out_last   = out_last_r;
  assign cmp_value  = val_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sul_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    found_r      <= found_nxt;
    kind_r       <= kind_nxt;
    val_r        <= val_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Next state, store access and result load
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    found_nxt      = found_r;
    kind_nxt       = kind_r;
    val_nxt        = val_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r[AW-1:0];
    mem_wdata      = val_r;
    mem_re         = 1'b0;
    mem_raddr      = idx_r[AW-1:0];

    case (state_r)
      sul_pkg::S_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_kind;
          val_nxt  = in_value;
          idx_nxt  = '0;
          if (in_kind == sul_pkg::KIND_ADD || in_kind == sul_pkg::KIND_DEL) begin
            state_nxt = sul_pkg::S_SCAN_RD;
          end else begin
            state_nxt = sul_pkg::S_DUMP_RD;
          end
        end
      end

      // scan: read entry, or stop at the end of the held entries
      sul_pkg::S_SCAN_RD: begin
        if (idx_r == count_r) begin
          pos_nxt   = idx_r;
          found_nxt = 1'b0;
          state_nxt = sul_pkg::S_DECIDE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = sul_pkg::S_SCAN_CMP;
        end
      end

      sul_pkg::S_SCAN_CMP: begin
        if (cmp_res.ahead) begin
          idx_nxt   = idx_inc[CW-1:0];
          state_nxt = sul_pkg::S_SCAN_RD;
        end else begin
          pos_nxt   = idx_r;
          found_nxt = cmp_res.equal;
          state_nxt = sul_pkg::S_DECIDE;
        end
      end

      sul_pkg::S_DECIDE: begin
        if (kind_r == sul_pkg::KIND_ADD) begin
          if (found_r || count_r == DEPTH_C) begin
            if (out_free) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = found_r ? sul_pkg::ST_PRESENT : sul_pkg::ST_FULL;
              out_entry_nxt  = val_r;
              out_count_nxt  = cnt_field(count_r);
              out_last_nxt   = 1'b1;
              state_nxt      = sul_pkg::S_IDLE;
            end
          end else begin
            idx_nxt   = count_r;
            state_nxt = sul_pkg::S_INS_RD;
          end
        end else begin
          if (found_r) begin
            idx_nxt   = pos_r;
            state_nxt = sul_pkg::S_DEL_RD;
          end else if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = sul_pkg::ST_NOTFOUND;
            out_entry_nxt  = val_r;
            out_count_nxt  = cnt_field(count_r);
            out_last_nxt   = 1'b1;
            state_nxt      = sul_pkg::S_IDLE;
          end
        end
      end

      // insert: move entries up one place from the tail down to the stop
      sul_pkg::S_INS_RD: begin
        if (idx_r == pos_r) begin
          if (out_free) begin
            mem_we         = 1'b1;
            count_nxt      = count_r + {{(CW-1){1'b0}}, 1'b1};
            out_valid_nxt  = 1'b1;
            out_status_nxt = sul_pkg::ST_INSERTED;
            out_entry_nxt  = val_r;
            out_count_nxt  = cnt_field(count_nxt);
            out_last_nxt   = 1'b1;
            state_nxt      = sul_pkg::S_IDLE;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_dec[AW-1:0];
          state_nxt = sul_pkg::S_INS_WR;
        end
      end

      sul_pkg::S_INS_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        idx_nxt   = idx_dec;
        state_nxt = sul_pkg::S_INS_RD;
      end

      // delete: move entries down one place from the stop to the tail
      sul_pkg::S_DEL_RD: begin
        if (idx_at_tail) begin
          if (out_free) begin
            count_nxt      = count_r - {{(CW-1){1'b0}}, 1'b1};
            out_valid_nxt  = 1'b1;
            out_status_nxt = sul_pkg::ST_REMOVED;
            out_entry_nxt  = val_r;
            out_count_nxt  = cnt_field(count_nxt);
            out_last_nxt   = 1'b1;
            state_nxt      = sul_pkg::S_IDLE;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc[AW-1:0];
          state_nxt = sul_pkg::S_DEL_WR;
        end
      end

      sul_pkg::S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        idx_nxt   = idx_inc[CW-1:0];
        state_nxt = sul_pkg::S_DEL_RD;
      end

      // dump: read the next entry, or report an empty store
      sul_pkg::S_DUMP_RD: begin
        if (count_r == '0) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = sul_pkg::ST_EMPTY;
            out_entry_nxt  = '0;
            out_count_nxt  = '0;
            out_last_nxt   = 1'b1;
            state_nxt      = sul_pkg::S_IDLE;
          end
        end else begin
          mem_re    = 1'b1;
          state_nxt = sul_pkg::S_DUMP_OUT;
        end
      end

      sul_pkg::S_DUMP_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = sul_pkg::ST_DUMP;
          out_entry_nxt  = mem_rdata;
          out_count_nxt  = cnt_field(count_r);
          out_last_nxt   = idx_at_tail;
          idx_nxt        = idx_inc[CW-1:0];
          state_nxt      = idx_at_tail ? sul_pkg::S_IDLE : sul_pkg::S_DUMP_RD;
        end
      end

      default: begin
        state_nxt = sul_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/sorted_unique_list_top.sv */
// Items are taken one at a time: add and delete scan the held entries and then
// shift, a dump reads each entry in turn, and a new item is accepted only in
// the idle state once the previous one has loaded its last result; the single
// store read port and shared compare unit set this.
// Reset (rst_n low, synchronous) clears the entry count and the order bit;
// store contents are left as they are and need no clearing pass.
// ----------------------------------------------------------------------------
// sorted_unique_list_top
// Bounded ordered set of distinct signed words with add, delete and dump
// items, an APB-style order setting and stream-style channels.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_list_top #(
  parameter int DEPTH = sul_pkg::DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // [31:0] value
  input  wire logic [1:0]  in_tuser,    // [1:0] kind
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,   // [31:0] entry, [36:32] count, [39:37] zero
  output logic [2:0]       out_tuser,   // [2:0] status
  output logic             out_tlast,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                          descending_r;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [sul_pkg::VALUE_W-1:0]   mem_wdata;
  logic                          mem_re;
  logic [AW-1:0]                 mem_raddr;
  logic [sul_pkg::VALUE_W-1:0]   mem_rdata;
  logic [sul_pkg::VALUE_W-1:0]   cmp_value;
  sul_pkg::cmp_res_t             cmp_res;
  logic [sul_pkg::VALUE_W-1:0]   out_entry;
  logic [sul_pkg::COUNT_W-1:0]   out_count;

  // Order register at byte address 0; other addresses read as zero
  assign pready = 1'b1;
  assign prdata = (paddr == sul_pkg::ADDR_DESCENDING) ? {31'd0, descending_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      descending_r <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr == sul_pkg::ADDR_DESCENDING) begin
      descending_r <= pwdata[0];
    end
  end

  assign out_tdata = {3'd0, out_count, out_entry};

  sul_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sul_cmp u_cmp (
    .descending (descending_r),
    .entry      (mem_rdata),
    .value      (cmp_value),
    .res        (cmp_res)
  );

  sul_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_value   (in_tdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_entry  (out_entry),
    .out_count  (out_count),
    .out_last   (out_tlast),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .cmp_value  (cmp_value),
    .cmp_res    (cmp_res)
  );

endmodule

`default_nettype wire

/* src/sul_chk.sv */
// ----------------------------------------------------------------------------
// sul_chk
// Port-level checks for the sorted unique list block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sul_chk #(
  parameter int DEPTH = sul_pkg::DEPTH_DEF
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [2:0]  out_tuser,
  input wire logic        out_tlast
);

  // A pending result stays offered until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before transfer");

  // One item at a time: busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in progress");

  // Status codes stay within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= sul_pkg::ST_EMPTY))
    else $error("undefined status code");

  // Empty dump: single result, zero entry and zero count
  a_empty_dump: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == sul_pkg::ST_EMPTY |->
      out_tlast && out_tdata[36:0] == 37'd0)
    else $error("malformed empty dump result");

  // Count never exceeds the store depth where the field can show it
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (DEPTH > 31) || (int'(out_tdata[36:32]) <= DEPTH))
    else $error("entry count above depth");

endmodule

bind sorted_unique_list_top sul_chk #(
  .DEPTH (DEPTH)
) u_sul_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

/* sim/sorted_unique_list_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_list_top_test
// Self-checking bench for the sorted unique list. A queue-fed driver sends
// add, delete and dump items with random gaps, and a monitor with random
// stalls checks every result against a local ordered-set model. The model
// tracks the order bit, which is changed between phases through the APB port.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_list_top_test;

  localparam int DEPTH       = sul_pkg::DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_GAP     = 5;

  // Kind codes with no name in the package
  localparam logic [sul_pkg::KIND_W-1:0] KIND_DUMP  = 2'd2;
  localparam logic [sul_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam logic [31:0] WORD_MIN = 32'h8000_0000;
  localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;

  typedef struct {
    logic [sul_pkg::KIND_W-1:0]  kind;
    logic [sul_pkg::VALUE_W-1:0] value;
  } list_op_t;

  typedef struct {
    logic [sul_pkg::STATUS_W-1:0] status;
    logic [sul_pkg::VALUE_W-1:0]  entry;
    logic [sul_pkg::COUNT_W-1:0]  count;
    logic                         last;
  } list_reply_t;

  // Clock, reset and DUT ports
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [31:0] value
  logic [1:0]  in_tuser   = '0;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [31:0] entry, [36:32] count, [39:37] zero
  logic [2:0]  out_tuser;         // [2:0] status
  logic        out_tlast;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [1:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;

  // Model of the ordered set
  logic [sul_pkg::VALUE_W-1:0] held_words [DEPTH];
  int                          held_count = 0;
  bit                          order_desc = 1'b0;

  list_op_t    pending_ops[$];
  list_reply_t expected_replies[$];
  int          ops_queued  = 0;
  int          ops_taken   = 0;
  int          error_count = 0;
  int          cycle_count = 0;

  // Idling state of both sides
  int          in_gap     = 0;
  bit          in_calm    = 1'b0;
  int          out_stall  = 0;
  int          stall_now;
  bit          out_calm   = 1'b0;
  list_op_t    next_op;

  sorted_unique_list_top #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // True when a held word sorts strictly ahead of the search value
  function automatic bit sorts_ahead(input logic [31:0] held, input logic [31:0] value);
    if (order_desc) return $signed(value) < $signed(held);
    return $signed(held) < $signed(value);
  endfunction

  function automatic void push_reply(input logic [2:0] status, input logic [31:0] entry,
                                     input bit last);
    list_reply_t r;
    r.status = status;
    r.entry  = entry;
    r.count  = held_count[sul_pkg::COUNT_W-1:0];
    r.last   = last;
    expected_replies.push_back(r);
  endfunction

  // Apply one item to the set model and queue the replies it produces
  function automatic void apply_list_op(input logic [1:0] kind, input logic [31:0] value);
    int pos;
    int i;
    bit hit;
    if (kind == sul_pkg::KIND_ADD || kind == sul_pkg::KIND_DEL) begin
      pos = 0;
      while (pos < held_count && sorts_ahead(held_words[pos], value)) pos++;
      hit = (pos < held_count) && (held_words[pos] == value);
      if (kind == sul_pkg::KIND_ADD) begin
        if (hit) begin
          push_reply(sul_pkg::ST_PRESENT, value, 1'b1);
        end else if (held_count >= DEPTH) begin
          push_reply(sul_pkg::ST_FULL, value, 1'b1);
        end else begin
          for (i = held_count; i > pos; i--) held_words[i] = held_words[i-1];
          held_words[pos] = value;
          held_count++;
          push_reply(sul_pkg::ST_INSERTED, value, 1'b1);
        end
      end else if (hit) begin
        for (i = pos; i + 1 < held_count; i++) held_words[i] = held_words[i+1];
        held_count--;
        push_reply(sul_pkg::ST_REMOVED, value, 1'b1);
      end else begin
        push_reply(sul_pkg::ST_NOTFOUND, value, 1'b1);
      end
    end else if (held_count == 0) begin
      push_reply(sul_pkg::ST_EMPTY, '0, 1'b1);
    end else begin
      for (i = 0; i < held_count; i++) begin
        push_reply(sul_pkg::ST_DUMP, held_words[i], i + 1 == held_count);
      end
    end
  endfunction

  function automatic void check_reply();
    list_reply_t e;
    if (expected_replies.size() == 0) begin
      $error("unexpected result: status %0d entry %0h", out_tuser, out_tdata[31:0]);
      error_count++;
      return;
    end
    e = expected_replies.pop_front();
    if (out_tuser !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, out_tuser);
      error_count++;
    end
    if (out_tdata[31:0] !== e.entry) begin
      $error("entry: expected %0d, actual %0d", $signed(e.entry), $signed(out_tdata[31:0]));
      error_count++;
    end
    if (out_tdata[36:32] !== e.count) begin
      $error("count: expected %0d, actual %0d", e.count, out_tdata[36:32]);
      error_count++;
    end
    if (out_tlast !== e.last) begin
      $error("last: expected %0d, actual %0d", e.last, out_tlast);
      error_count++;
    end
  endfunction

  // Input driver: presents queued items, random gap after each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_list_op(in_tuser, in_tdata);
        ops_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          next_op = pending_ops.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_op.value;
          in_tuser  <= next_op.kind;
          if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
          in_gap    <= in_calm ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transfer, random stall after each one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall  <= 0;
    end else begin
      stall_now = out_stall;
      if (out_tvalid && out_tready) begin
        check_reply();
        if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
        stall_now = out_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall_now > 0) begin
        out_tready <= 1'b0;
        out_stall  <= stall_now - 1;
      end else begin
        out_tready <= 1'b1;
        out_stall  <= 0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic queue_op(input logic [1:0] kind, input logic [31:0] value);
    list_op_t op;
    op.kind  = kind;
    op.value = value;
    pending_ops.push_back(op);
    ops_queued++;
  endtask

  // Block until every item is taken and every reply has arrived
  task automatic wait_drained(input int settle);
    do @(posedge clk); while (!(ops_taken == ops_queued && expected_replies.size() == 0));
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_order(input bit desc);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= sul_pkg::ADDR_DESCENDING;
    pwdata  <= {31'd0, desc};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    order_desc = desc;
  endtask

  // Mostly small values so adds and deletes collide, plus extremes and noise
  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r == 1) begin
      case ($urandom_range(0, 3))
        0: return WORD_MIN;
        1: return WORD_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    return 32'($urandom_range(0, 23)) - 32'd12;
  endfunction

  task automatic queue_random_ops(input int n, input int add_pct, input int del_pct);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) queue_op(sul_pkg::KIND_ADD, pick_value());
      else if (r < add_pct + del_pct) queue_op(sul_pkg::KIND_DEL, pick_value());
      else queue_op(($urandom_range(0, 3) == 0) ? KIND_SPARE : KIND_DUMP, $urandom);
    end
  endtask

  initial begin
    int k;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_order(1'b0);

    // Directed: empty dump, extremes, duplicates, delete hits and misses
    queue_op(KIND_DUMP, 32'h1234_5678);
    queue_op(sul_pkg::KIND_ADD, 32'd0);
    queue_op(sul_pkg::KIND_ADD, WORD_MIN);
    queue_op(sul_pkg::KIND_ADD, WORD_MAX);
    queue_op(sul_pkg::KIND_ADD, '1);
    queue_op(sul_pkg::KIND_ADD, 32'd0);
    queue_op(sul_pkg::KIND_ADD, 32'd1);
    queue_op(KIND_DUMP, '1);
    queue_op(sul_pkg::KIND_DEL, 32'd5);
    queue_op(sul_pkg::KIND_DEL, WORD_MIN);
    queue_op(sul_pkg::KIND_DEL, WORD_MAX);
    queue_op(KIND_SPARE, '0);
    // Fill to the brim, then overflow and a duplicate while full
    for (k = 1; k <= DEPTH - 3; k++) queue_op(sul_pkg::KIND_ADD, 32'(k * 100));
    queue_op(sul_pkg::KIND_ADD, 32'd5000);
    queue_op(sul_pkg::KIND_ADD, 32'd0);
    queue_op(KIND_DUMP, '0);
    wait_drained(4);

    // Random phases; the first flips the order while the store is full
    write_order(1'b1);
    queue_random_ops(50, 35, 50);
    wait_drained(4);
    write_order(1'b0);
    queue_random_ops(50, 30, 55);
    wait_drained(4);
    write_order(1'b1);
    queue_random_ops(50, 65, 20);
    wait_drained(4);
    write_order(1'b0);
    queue_random_ops(50, 60, 25);
    wait_drained(4);
    write_order(1'b1);
    queue_random_ops(50, 40, 45);
    wait_drained(2 * DEPTH + 8);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
src/sul_pkg.sv
src/sul_mem.sv
src/sul_cmp.sv
src/sul_seq.sv
src/sorted_unique_list_top.sv
src/sul_chk.sv
sim/sorted_unique_list_top_test.sv
